// File: rtl/ipv4lpm_pkg.sv
`default_nettype none

package ipv4lpm_pkg;

    localparam int ADDR_W = 32;
    localparam int LEN_W  = 6;
    localparam int PORT_W = 3;
    localparam int TTL_W  = 8;

    localparam logic [LEN_W-1:0] MAX_LEN = 6'd32;

    localparam logic CMD_ADD   = 1'b0;
    localparam logic CMD_ROUTE = 1'b1;

    typedef enum logic [2:0] {
        STAT_ADDED     = 3'd0,
        STAT_FORWARDED = 3'd1,
        STAT_DROP_TTL  = 3'd2,
        STAT_NO_ROUTE  = 3'd3,
        STAT_FULL      = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        CS_IDLE,
        CS_SEARCH,
        CS_HOLD
    } t_ctl_state;

    // one stored route
    typedef struct packed {
        logic [ADDR_W-1:0] prefix;
        logic [LEN_W-1:0]  len;
        logic [ADDR_W-1:0] gateway;
        logic              direct;
        logic [PORT_W-1:0] port;
    } t_entry;

    // search token walking down the cell chain, carries the best match so far
    typedef struct packed {
        logic              valid;
        logic [ADDR_W-1:0] dest;
        logic              found;
        logic [LEN_W-1:0]  len;
        logic [PORT_W-1:0] port;
        logic [ADDR_W-1:0] hop;
    } t_token;

    // top len bits set, len of 32 or more gives all ones
    function automatic logic [ADDR_W-1:0] prefix_mask(input logic [LEN_W-1:0] len);
        return ~({ADDR_W{1'b1}} >> len);
    endfunction

endpackage

`default_nettype wire

// File: rtl/ipv4lpm_if.sv
`default_nettype none

interface ipv4lpm_req_if;
    logic        valid;
    logic        ready;
    logic        cmd;
    logic [31:0] route_addr;
    logic [5:0]  route_len;
    logic        has_gateway;
    logic [31:0] gateway_addr;
    logic [2:0]  route_port;
    logic [31:0] dest_addr;
    logic [7:0]  ttl_in;

    modport source (
        output valid, cmd, route_addr, route_len, has_gateway, gateway_addr,
               route_port, dest_addr, ttl_in,
        input  ready
    );
    modport sink (
        input  valid, cmd, route_addr, route_len, has_gateway, gateway_addr,
               route_port, dest_addr, ttl_in,
        output ready
    );
endinterface

interface ipv4lpm_rsp_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [2:0]  out_port;
    logic [31:0] hop_addr;
    logic [7:0]  ttl_out;

    modport source (
        output valid, status, out_port, hop_addr, ttl_out,
        input  ready
    );
    modport sink (
        input  valid, status, out_port, hop_addr, ttl_out,
        output ready
    );
endinterface

`default_nettype wire

// File: rtl/ipv4_longest_prefix_router_unit.sv
`default_nettype none

// channel  | dir | handshake           | payload
// i_req    | in  | valid/ready         | cmd, route, gateway, port, dest, ttl
// o_rsp    | out | valid/ready         | status, out_port, hop_addr, ttl_out
//
// one item in flight: i_req.ready is high only while the block is idle.
// an add or a ttl drop goes from the pending register to the output register
// once the output is free; only then can the next item be taken.
// a lookup first walks the search token through the route cells, one per
// cycle, then goes through the pending and the output register, so the
// chain length sets how long each lookup takes before the next is taken.
// a result that is not taken holds in the output register; a finished next
// result waits in the pending register until the output frees up.
// synchronous active-low reset empties the table (entry count to zero).
module ipv4_longest_prefix_router_unit #(
    parameter int TABLE_DEPTH = 32,
    parameter int NUM_PORTS   = 8
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    ipv4lpm_req_if.sink   i_req,
    ipv4lpm_rsp_if.source o_rsp
);
    import ipv4lpm_pkg::*;

    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

    t_ctl_state r_state;
    t_ctl_state n_state;

    logic [CNT_W-1:0] r_count;

    t_token tok [0:TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] cell_active;
    logic [TABLE_DEPTH-1:0] cell_wr;
    t_entry wr_entry;

    logic req_acc;
    logic is_add;
    logic ttl_drop;
    logic table_full;
    logic out_load;
    logic [6:0] port_red;

    t_status           r_pend_status;
    logic [PORT_W-1:0] r_pend_port;
    logic [ADDR_W-1:0] r_pend_hop;
    logic [TTL_W-1:0]  r_pend_ttl;

    logic              r_out_valid;
    t_status           r_out_status;
    logic [PORT_W-1:0] r_out_port;
    logic [ADDR_W-1:0] r_out_hop;
    logic [TTL_W-1:0]  r_out_ttl;

    assign i_req.ready = (r_state == CS_IDLE);
    assign req_acc     = i_req.valid && i_req.ready;
    assign is_add      = (i_req.cmd == CMD_ADD);
    assign ttl_drop    = (i_req.ttl_in <= 8'd1);
    assign table_full  = (r_count == CNT_W'(TABLE_DEPTH));

    // port reduced modulo NUM_PORTS by repeated subtract on a 3-bit value
    always_comb begin
        port_red = {4'b0, i_req.route_port};
        for (int k = 0; k < 7; k++) begin
            if (port_red >= 7'(NUM_PORTS)) begin
                port_red = port_red - 7'(NUM_PORTS);
            end
        end
    end

    always_comb begin
        wr_entry.prefix  = i_req.route_addr;
        wr_entry.len     = (i_req.route_len > MAX_LEN) ? MAX_LEN : i_req.route_len;
        wr_entry.gateway = i_req.gateway_addr;
        wr_entry.direct  = !i_req.has_gateway;
        wr_entry.port    = port_red[PORT_W-1:0];
    end

    always_comb begin
        tok[0].valid = req_acc && (i_req.cmd == CMD_ROUTE) && !ttl_drop;
        tok[0].dest  = i_req.dest_addr;
        tok[0].found = 1'b0;
        tok[0].len   = '0;
        tok[0].port  = '0;
        tok[0].hop   = '0;
    end

    for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
        assign cell_active[g] = (CNT_W'(g) < r_count);
        assign cell_wr[g]     = req_acc && is_add && !table_full
                             && (r_count == CNT_W'(g));

        ipv4lpm_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_active   (cell_active[g]),
            .i_wr_en    (cell_wr[g]),
            .i_wr_entry (wr_entry),
            .i_tok      (tok[g]),
            .o_tok      (tok[g+1])
        );
    end

    always_comb begin
        n_state  = r_state;
        out_load = 1'b0;
        case (r_state)
            CS_IDLE: begin
                if (req_acc) begin
                    n_state = (is_add || ttl_drop) ? CS_HOLD : CS_SEARCH;
                end
            end
            CS_SEARCH: begin
                if (tok[TABLE_DEPTH].valid) begin
                    n_state = CS_HOLD;
                end
            end
            CS_HOLD: begin
                if (!r_out_valid || o_rsp.ready) begin
                    out_load = 1'b1;
                    n_state  = CS_IDLE;
                end
            end
            default: begin
                n_state = CS_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= CS_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (req_acc && is_add && !table_full) begin
                r_count <= r_count + CNT_W'(1);
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (req_acc) begin
            r_pend_port <= '0;
            r_pend_hop  <= '0;
            if (is_add) begin
                r_pend_status <= table_full ? STAT_FULL : STAT_ADDED;
                r_pend_ttl    <= '0;
            end else if (ttl_drop) begin
                r_pend_status <= STAT_DROP_TTL;
                r_pend_ttl    <= '0;
            end else begin
                r_pend_status <= STAT_NO_ROUTE;
                r_pend_ttl    <= i_req.ttl_in - 8'd1;
            end
        end else if (r_state == CS_SEARCH && tok[TABLE_DEPTH].valid) begin
            if (tok[TABLE_DEPTH].found) begin
                r_pend_status <= STAT_FORWARDED;
                r_pend_port   <= tok[TABLE_DEPTH].port;
                r_pend_hop    <= tok[TABLE_DEPTH].hop;
            end else begin
                r_pend_status <= STAT_NO_ROUTE;
                r_pend_ttl    <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_status <= r_pend_status;
            r_out_port   <= r_pend_port;
            r_out_hop    <= r_pend_hop;
            r_out_ttl    <= r_pend_ttl;
        end
    end

    assign o_rsp.valid    = r_out_valid;
    assign o_rsp.status   = r_out_status;
    assign o_rsp.out_port = r_out_port;
    assign o_rsp.hop_addr = r_out_hop;
    assign o_rsp.ttl_out  = r_out_ttl;

endmodule

`default_nettype wire

// File: rtl/ipv4lpm_cell.sv
`default_nettype none

module ipv4lpm_cell (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_active,
    input  logic                i_wr_en,
    input  ipv4lpm_pkg::t_entry i_wr_entry,
    input  ipv4lpm_pkg::t_token i_tok,
    output ipv4lpm_pkg::t_token o_tok
);
    import ipv4lpm_pkg::*;

    t_entry r_entry;
    t_token r_tok;
    t_token n_tok;
    logic   hit;
    logic   take;

    always_comb begin
        hit  = i_active
            && (((i_tok.dest ^ r_entry.prefix) & prefix_mask(r_entry.len)) == '0);
        // strictly longer only, so the earliest entry keeps a tie
        take = hit && (!i_tok.found || (r_entry.len > i_tok.len));
        n_tok = i_tok;
        if (take) begin
            n_tok.found = 1'b1;
            n_tok.len   = r_entry.len;
            n_tok.port  = r_entry.port;
            n_tok.hop   = r_entry.direct ? i_tok.dest : r_entry.gateway;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_entry <= i_wr_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok.valid <= 1'b0;
        end else begin
            r_tok.valid <= n_tok.valid;
        end
        r_tok.dest  <= n_tok.dest;
        r_tok.found <= n_tok.found;
        r_tok.len   <= n_tok.len;
        r_tok.port  <= n_tok.port;
        r_tok.hop   <= n_tok.hop;
    end

    assign o_tok = r_tok;

endmodule

`default_nettype wire

// File: rtl/ipv4lpm_chk.sv
`default_nettype none

module ipv4lpm_chk (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_req_valid,
    input wire logic        i_req_ready,
    input wire logic        i_rsp_valid,
    input wire logic        i_rsp_ready,
    input wire logic [2:0]  i_status,
    input wire logic [2:0]  i_out_port,
    input wire logic [31:0] i_hop_addr,
    input wire logic [7:0]  i_ttl_out
);
    import ipv4lpm_pkg::*;

    // one item at a time: the block is busy right after taking an item
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req_valid && i_req_ready) |=> !i_req_ready)
        else $error("input ready right after an item was accepted");

    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && !i_rsp_ready) |=> (i_rsp_valid && $stable(i_status)
            && $stable(i_hop_addr) && $stable(i_ttl_out) && $stable(i_out_port)))
        else $error("stalled result changed");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid |-> (i_status == STAT_ADDED || i_status == STAT_FORWARDED
            || i_status == STAT_DROP_TTL || i_status == STAT_NO_ROUTE
            || i_status == STAT_FULL))
        else $error("result status out of range");

    a_zero_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && i_status != STAT_FORWARDED)
            |-> (i_out_port == '0 && i_hop_addr == '0 && i_ttl_out == '0))
        else $error("non-forwarded result carries data");

    a_fwd_ttl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && i_status == STAT_FORWARDED) |-> (i_ttl_out != 8'd0))
        else $error("forwarded item with expired ttl");

endmodule

bind ipv4_longest_prefix_router_unit ipv4lpm_chk u_ipv4lpm_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_req_valid (i_req.valid),
    .i_req_ready (i_req.ready),
    .i_rsp_valid (o_rsp.valid),
    .i_rsp_ready (o_rsp.ready),
    .i_status    (o_rsp.status),
    .i_out_port  (o_rsp.out_port),
    .i_hop_addr  (o_rsp.hop_addr),
    .i_ttl_out   (o_rsp.ttl_out)
);

`default_nettype wire

// File: tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import ipv4lpm_pkg::*;

    localparam int ROUTE_SLOTS = 32;
    localparam int PORT_COUNT  = 8;
    localparam int CYCLE_LIMIT = 500000;
    localparam int SETTLE_CYCLES = 2 * ROUTE_SLOTS + 20;

    typedef struct {
        logic              cmd;
        logic [ADDR_W-1:0] route_addr;
        logic [LEN_W-1:0]  route_len;
        logic              has_gateway;
        logic [ADDR_W-1:0] gateway_addr;
        logic [PORT_W-1:0] route_port;
        logic [ADDR_W-1:0] dest_addr;
        logic [TTL_W-1:0]  ttl_in;
    } t_route_req;

    typedef struct {
        t_status           status;
        logic [PORT_W-1:0] out_port;
        logic [ADDR_W-1:0] hop_addr;
        logic [TTL_W-1:0]  ttl_out;
    } t_verdict;

    logic i_clk;
    logic i_rst_n;

    ipv4lpm_req_if req_bus ();
    ipv4lpm_rsp_if rsp_bus ();

    ipv4_longest_prefix_router_unit #(
        .TABLE_DEPTH(ROUTE_SLOTS),
        .NUM_PORTS  (PORT_COUNT)
    ) i_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req_bus),
        .o_rsp  (rsp_bus)
    );

    // shadow copy of the route table
    logic [ADDR_W-1:0] rt_prefix  [ROUTE_SLOTS];
    logic [LEN_W-1:0]  rt_len     [ROUTE_SLOTS];
    logic [ADDR_W-1:0] rt_gateway [ROUTE_SLOTS];
    logic              rt_direct  [ROUTE_SLOTS];
    logic [PORT_W-1:0] rt_port    [ROUTE_SLOTS];
    int                route_count;

    t_verdict expected_verdicts[$];
    bit       fail_seen;
    bit       steady_flow;
    int       sink_stall;
    int       cycle_count;

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (steady_flow || r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(4, 30);
    endfunction

    // applies one item to the shadow table and works out the response it must get
    function automatic t_verdict forward_decision(input t_route_req rq);
        t_verdict v;
        int       best;
        v.status   = STAT_ADDED;
        v.out_port = '0;
        v.hop_addr = '0;
        v.ttl_out  = '0;
        if (rq.cmd == CMD_ADD) begin
            if (route_count >= ROUTE_SLOTS) begin
                v.status = STAT_FULL;
            end else begin
                rt_prefix[route_count]  = rq.route_addr;
                rt_len[route_count]     = (rq.route_len > MAX_LEN) ? MAX_LEN : rq.route_len;
                rt_direct[route_count]  = !rq.has_gateway;
                rt_gateway[route_count] = rq.gateway_addr;
                rt_port[route_count]    = PORT_W'(rq.route_port % PORT_COUNT);
                route_count++;
            end
        end else if (rq.ttl_in <= 1) begin
            v.status = STAT_DROP_TTL;
        end else begin
            best = -1;
            for (int i = 0; i < route_count; i++) begin
                // shift by the full width leaves zero, so length 0 always hits
                if (((rq.dest_addr ^ rt_prefix[i]) >> (ADDR_W - rt_len[i])) == 0 &&
                    (best < 0 || rt_len[i] > rt_len[best]))
                    best = i;
            end
            if (best < 0) begin
                v.status = STAT_NO_ROUTE;
            end else begin
                v.status   = STAT_FORWARDED;
                v.out_port = rt_port[best];
                v.hop_addr = rt_direct[best] ? rq.dest_addr : rt_gateway[best];
                v.ttl_out  = rq.ttl_in - 1'b1;
            end
        end
        return v;
    endfunction

    function automatic t_route_req random_fields();
        t_route_req rq;
        rq.cmd          = 1'($urandom_range(0, 1));
        rq.route_addr   = $urandom();
        rq.route_len    = LEN_W'($urandom_range(0, 63));
        rq.has_gateway  = 1'($urandom_range(0, 1));
        rq.gateway_addr = $urandom();
        rq.route_port   = PORT_W'($urandom_range(0, 7));
        rq.dest_addr    = $urandom();
        rq.ttl_in       = TTL_W'($urandom_range(0, 255));
        return rq;
    endfunction

    function automatic t_route_req make_add(input logic [ADDR_W-1:0] prefix,
                                            input logic [LEN_W-1:0] len, input logic gw_valid,
                                            input logic [ADDR_W-1:0] gw,
                                            input logic [PORT_W-1:0] port);
        t_route_req rq;
        rq              = random_fields();
        rq.cmd          = CMD_ADD;
        rq.route_addr   = prefix;
        rq.route_len    = len;
        rq.has_gateway  = gw_valid;
        rq.gateway_addr = gw;
        rq.route_port   = port;
        return rq;
    endfunction

    function automatic t_route_req make_lookup(input logic [ADDR_W-1:0] dest,
                                               input logic [TTL_W-1:0] ttl);
        t_route_req rq;
        rq           = random_fields();
        rq.cmd       = CMD_ROUTE;
        rq.dest_addr = dest;
        rq.ttl_in    = ttl;
        return rq;
    endfunction

    // destination under a stored prefix, sometimes with one prefix bit flipped
    function automatic logic [ADDR_W-1:0] dest_near_route(input int k);
        logic [ADDR_W-1:0] keep;
        logic [ADDR_W-1:0] dest;
        keep = {ADDR_W{1'b1}} << (ADDR_W - rt_len[k]);
        dest = (rt_prefix[k] & keep) | ($urandom() & ~keep);
        if (rt_len[k] != 0 && $urandom_range(0, 4) == 0)
            dest ^= 32'd1 << (ADDR_W - $urandom_range(1, rt_len[k]));
        return dest;
    endfunction

    function automatic t_route_req random_request(input int add_pct);
        t_route_req rq;
        int         r;
        rq = random_fields();
        if ($urandom_range(0, 99) < add_pct) begin
            rq.cmd = CMD_ADD;
            r = $urandom_range(0, 99);
            if (r < 5) rq.route_len = '0;
            else if (r < 12) rq.route_len = LEN_W'($urandom_range(33, 63));
            else if (r < 20) rq.route_len = 6'd32;
            else rq.route_len = LEN_W'($urandom_range(1, 31));
            // nest new routes under old ones to exercise the longest match
            if (route_count != 0 && $urandom_range(0, 9) < 3)
                rq.route_addr = dest_near_route($urandom_range(0, route_count - 1));
        end else begin
            rq.cmd = CMD_ROUTE;
            if (route_count != 0 && $urandom_range(0, 9) < 7)
                rq.dest_addr = dest_near_route($urandom_range(0, route_count - 1));
            rq.ttl_in = ($urandom_range(0, 99) < 8) ? TTL_W'($urandom_range(0, 1))
                                                     : TTL_W'($urandom_range(2, 255));
        end
        return rq;
    endfunction

    // leaves valid high on return so a back-to-back item follows without valid dropping
    task automatic send_request(input t_route_req rq);
        int gap;
        gap = pick_gap();
        if (gap != 0) begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_bus.cmd          <= rq.cmd;
        req_bus.route_addr   <= rq.route_addr;
        req_bus.route_len    <= rq.route_len;
        req_bus.has_gateway  <= rq.has_gateway;
        req_bus.gateway_addr <= rq.gateway_addr;
        req_bus.route_port   <= rq.route_port;
        req_bus.dest_addr    <= rq.dest_addr;
        req_bus.ttl_in       <= rq.ttl_in;
        req_bus.valid        <= 1'b1;
        do @(posedge i_clk); while (!req_bus.ready);
        expected_verdicts.push_back(forward_decision(rq));
    endtask

    task automatic wait_drained();
        req_bus.valid <= 1'b0;
        while (expected_verdicts.size() != 0) @(posedge i_clk);
    endtask

    task automatic test_empty_table();
        send_request(make_lookup(32'h0A00_0001, 8'd64));
        send_request(make_lookup(32'hFFFF_FFFF, 8'd255));
        send_request(make_lookup(32'h0A00_0001, 8'd0));
        send_request(make_lookup(32'h0A00_0001, 8'd1));
    endtask

    task automatic test_directed_routes();
        send_request(make_add(32'h0A00_0000, 6'd8, 1'b1, 32'hC0A8_0001, 3'd1));
        // direct route, gateway field must be ignored
        send_request(make_add(32'h0A01_0000, 6'd16, 1'b0, 32'hDEAD_BEEF, 3'd2));
        // oversized length saturates to a host route
        send_request(make_add(32'h0A01_0203, 6'd63, 1'b1, 32'hFFFF_FFFF, 3'd3));
        // same prefix and length as an earlier entry, earlier one must win
        send_request(make_add(32'h0A01_0000, 6'd16, 1'b1, 32'h0102_0304, 3'd4));
        send_request(make_lookup(32'h0A01_0203, 8'd255));
        send_request(make_lookup(32'h0A01_0204, 8'd2));
        send_request(make_lookup(32'h0A09_0909, 8'd100));
        send_request(make_lookup(32'h0B00_0000, 8'd9));
        send_request(make_add(32'h1234_5678, 6'd0, 1'b1, 32'hFFFF_FFFE, 3'd7));
        send_request(make_lookup(32'hFFFF_FFFF, 8'd255));
        send_request(make_lookup(32'h0000_0000, 8'd3));
        send_request(make_add(32'hFFFF_FFFF, 6'd32, 1'b0, 32'h0000_0000, 3'd0));
        send_request(make_lookup(32'hFFFF_FFFF, 8'd128));
        send_request(make_lookup(32'h0A01_0203, 8'd1));
        send_request(make_add(32'h8000_0000, 6'd1, 1'b1, 32'h0000_0000, 3'd5));
        send_request(make_lookup(32'h8000_0001, 8'd10));
        send_request(make_lookup(32'h7FFF_FFFF, 8'd10));
    endtask

    task automatic test_random_traffic(input int n_items, input int add_pct);
        for (int i = 0; i < n_items; i++)
            send_request(random_request(add_pct));
    endtask

    task automatic test_table_full();
        while (route_count < ROUTE_SLOTS)
            send_request(random_request(100));
        repeat (4) send_request(random_request(100));
        send_request(make_lookup($urandom(), 8'd200));
    endtask

    task automatic test_back_to_back();
        steady_flow = 1'b1;
        test_random_traffic(80, 10);
        steady_flow = 1'b0;
    endtask

    task automatic test_drain_pause();
        repeat (3) begin
            test_random_traffic(8, 10);
            wait_drained();
            repeat ($urandom_range(5, 40)) @(posedge i_clk);
        end
    endtask

    // response side: random backpressure
    always @(posedge i_clk) begin
        if (sink_stall != 0) begin
            rsp_bus.ready <= 1'b0;
            sink_stall    <= sink_stall - 1;
        end else begin
            rsp_bus.ready <= 1'b1;
            if (rsp_bus.valid && rsp_bus.ready)
                sink_stall <= pick_gap();
        end
    end

    always @(posedge i_clk) begin : result_check
        t_verdict exp_v;
        if (i_rst_n && rsp_bus.valid && rsp_bus.ready) begin
            if (expected_verdicts.size() == 0) begin
                $error("unexpected item status=%0d", rsp_bus.status);
                fail_seen = 1'b1;
            end else begin
                exp_v = expected_verdicts.pop_front();
                if (rsp_bus.status !== exp_v.status) begin
                    $error("status expected %0d got %0d", exp_v.status, rsp_bus.status);
                    fail_seen = 1'b1;
                end
                if (rsp_bus.out_port !== exp_v.out_port) begin
                    $error("out_port expected %0d got %0d", exp_v.out_port, rsp_bus.out_port);
                    fail_seen = 1'b1;
                end
                if (rsp_bus.hop_addr !== exp_v.hop_addr) begin
                    $error("hop_addr expected %h got %h", exp_v.hop_addr, rsp_bus.hop_addr);
                    fail_seen = 1'b1;
                end
                if (rsp_bus.ttl_out !== exp_v.ttl_out) begin
                    $error("ttl_out expected %0d got %0d", exp_v.ttl_out, rsp_bus.ttl_out);
                    fail_seen = 1'b1;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    initial begin
        i_rst_n              = 1'b0;
        req_bus.valid        = 1'b0;
        req_bus.cmd          = CMD_ADD;
        req_bus.route_addr   = '0;
        req_bus.route_len    = '0;
        req_bus.has_gateway  = 1'b0;
        req_bus.gateway_addr = '0;
        req_bus.route_port   = '0;
        req_bus.dest_addr    = '0;
        req_bus.ttl_in       = '0;
        rsp_bus.ready        = 1'b0;
        route_count          = 0;
        fail_seen            = 1'b0;
        steady_flow          = 1'b0;
        sink_stall           = 0;
        cycle_count          = 0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_table();
        test_directed_routes();
        test_random_traffic(650, 4);
        test_table_full();
        test_back_to_back();
        test_drain_pause();
        test_random_traffic(120, 10);

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (!fail_seen && expected_verdicts.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// File: sim.f
rtl/ipv4lpm_pkg.sv
rtl/ipv4lpm_if.sv
rtl/ipv4lpm_cell.sv
rtl/ipv4_longest_prefix_router_unit.sv
rtl/ipv4lpm_chk.sv
tb/tb_top.sv
